/* hdl/tsrl_pkg.sv */
// ----------------------------------------------------------------------------
// tsrl_pkg
// Shared types and fixed widths of the timed sample ring lookup block.
// ----------------------------------------------------------------------------
package tsrl_pkg;

	localparam int STAMP_W     = 64;
	localparam int PAYLOAD_W   = 64;
	localparam int IN_TUSER_W  = 5;
	localparam int IN_TDATA_W  = 128;
	localparam int OUT_TUSER_W = 2;
	localparam int OUT_TDATA_W = 256;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRACK,
		ST_FIRST,
		ST_STEP,
		ST_CMP,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic load;
		logic append;
		logic set_empty;
		logic rd_first;
		logic chk_first;
		logic rd_mid;
		logic cmp_mid;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic query;
		logic veh_ok;
		logic hit;
		logic early;
		logic more;
		logic out_free;
	} sts_t;

endpackage

/* hdl/timed_sample_ring_lookup.sv */
// ----------------------------------------------------------------------------
// timed_sample_ring_lookup
// Per-vehicle rings of timestamped samples with a binary-search time lookup.
// ----------------------------------------------------------------------------
// Input stream s_*: one item is an append (tuser bit 0 low) or a query
// (tuser bit 0 high) for the vehicle in tuser bits 4:1. An append stores the
// stamp and payload at the ring head and widens the recorded span; it gives
// no result. A query returns the newest held sample at or below its time,
// or the oldest with before_first set, or found low for an empty ring.
// Output stream m_*: one result per query, with the global span attached.
// Steps: an append is loaded, then written. A query is loaded, then reads
// its oldest sample, then reads and compares a midpoint per search step,
// paced by the single registered read port of the ring memory; it skips the
// search when its time precedes the oldest sample, and all reads when empty.
// Items are taken one at a time. A finished result sits in the output
// register while the next item is accepted; a stalled receiver holds the
// block only when a second result is ready. Reset empties every ring and
// clears the span; ring contents need no clearing pass.
// ----------------------------------------------------------------------------
module timed_sample_ring_lookup import tsrl_pkg::*; #(
	parameter int VEHICLES = 16,
	parameter int DEPTH    = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // stamp, payload
	input  logic [IN_TUSER_W-1:0]  s_tuser,   // action, vehicle
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // sample_stamp, sample_payload,
	                                          // span_start, span_head
	output logic [OUT_TUSER_W-1:0] m_tuser    // found, before_first
);

	cmd_t cmd;
	sts_t sts;

	tsrl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.sts      (sts),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	tsrl_dp #(
		.VEHICLES (VEHICLES),
		.DEPTH    (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

`ifndef SYNTH
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in work");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!m_tvalid || m_tready))
		else $error("result register overwritten while stalled");

	a_before_implies_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("before_first set without found");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.out_ld))
		else $error("result shown without a load");
`endif

endmodule

/* hdl/tsrl_ctrl.sv */
// ----------------------------------------------------------------------------
// tsrl_ctrl
// Sequencer for appends and binary-search queries over the track rings.
// ----------------------------------------------------------------------------
module tsrl_ctrl import tsrl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  sts_t sts,
	output logic s_tready,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nx = ST_TRACK;
			end
			ST_TRACK: begin
				if (!sts.query) state_nx = ST_IDLE;
				else if (sts.hit) state_nx = ST_FIRST;
				else state_nx = ST_RESULT;
			end
			ST_FIRST: begin
				state_nx = sts.early ? ST_RESULT : ST_STEP;
			end
			ST_STEP: begin
				state_nx = sts.more ? ST_CMP : ST_RESULT;
			end
			ST_CMP: begin
				state_nx = ST_STEP;
			end
			ST_RESULT: begin
				if (sts.out_free) state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_TRACK: begin
				cmd.append    = !sts.query && sts.veh_ok;
				cmd.set_empty = sts.query && !sts.hit;
				cmd.rd_first  = sts.query && sts.hit;
			end
			ST_FIRST: begin
				cmd.chk_first = 1'b1;
			end
			ST_STEP: begin
				cmd.rd_mid = sts.more;
			end
			ST_CMP: begin
				cmd.cmp_mid = 1'b1;
			end
			ST_RESULT: begin
				cmd.out_ld = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* hdl/tsrl_dp.sv */
// ----------------------------------------------------------------------------
// tsrl_dp
// Ring and track memories, search registers, span tracking, result register.
// ----------------------------------------------------------------------------
module tsrl_dp import tsrl_pkg::*; #(
	parameter int VEHICLES = 16,
	parameter int DEPTH    = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IN_TUSER_W-1:0]  s_tuser,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   m_tready,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	output logic                   m_tvalid,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic [OUT_TUSER_W-1:0] m_tuser
);

	localparam int VW    = (VEHICLES > 1) ? $clog2(VEHICLES) : 1;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int SLOTS = VEHICLES * DEPTH;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int WW    = STAMP_W + PAYLOAD_W;

	logic [VW-1:0]             in_idx;
	logic                      query_q;
	logic signed [STAMP_W-1:0] stamp_q;
	logic [PAYLOAD_W-1:0]      payload_q;
	logic [VW-1:0]             idx_q;
	logic                      veh_ok_q;
	logic [AW-1:0]             base_q;

	logic [PW+CW-1:0]          trk_mem [VEHICLES];
	logic [PW+CW-1:0]          trk_rd_q;
	logic                      trk_vld_q;
	logic [VEHICLES-1:0]       vld_q;

	logic [WW-1:0]             ring_mem [SLOTS];
	logic [WW-1:0]             ring_rd_q;

	logic [PW-1:0]             head;
	logic [CW-1:0]             count;
	logic [PW-1:0]             head_nx;
	logic [CW-1:0]             count_nx;
	logic [PW:0]               start_sum;
	logic [PW-1:0]             start;

	logic [PW-1:0]             start_q;
	logic [PW-1:0]             lo_q;
	logic [PW-1:0]             hi_q;
	logic [PW-1:0]             mid_q;
	logic [PW:0]               span_w;
	logic [PW-1:0]             mid_nx;
	logic [PW-1:0]             rd_base;
	logic [PW-1:0]             rd_off;
	logic [PW:0]               psum;
	logic [PW-1:0]             phys;
	logic [AW-1:0]             rd_addr;
	logic [AW-1:0]             wr_addr;

	logic signed [STAMP_W-1:0] rd_stamp;
	logic                      early;

	logic                      res_found_q;
	logic                      res_bf_q;
	logic [WW-1:0]             res_data_q;

	logic signed [STAMP_W-1:0] earliest_q;
	logic signed [STAMP_W-1:0] latest_q;
	logic                      seen_q;

	logic                      m_tvalid_q;
	logic [OUT_TDATA_W-1:0]    m_tdata_q;
	logic [OUT_TUSER_W-1:0]    m_tuser_q;

	assign in_idx = VW'(s_tuser[4:1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_q   <= 1'b0;
			veh_ok_q  <= 1'b0;
			trk_vld_q <= 1'b0;
			vld_q     <= '0;
		end else begin
			if (cmd.load) begin
				query_q   <= s_tuser[0];
				veh_ok_q  <= (int'(s_tuser[4:1]) < VEHICLES);
				trk_vld_q <= vld_q[in_idx];
			end
			if (cmd.append) vld_q[idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			stamp_q   <= s_tdata[STAMP_W-1:0];
			payload_q <= s_tdata[IN_TDATA_W-1:STAMP_W];
			idx_q     <= in_idx;
			base_q    <= AW'(in_idx) * AW'(DEPTH);
			trk_rd_q  <= trk_mem[in_idx];
		end
		if (cmd.append) trk_mem[idx_q] <= {head_nx, count_nx};
	end

	assign head  = trk_vld_q ? trk_rd_q[PW+CW-1:CW] : '0;
	assign count = trk_vld_q ? trk_rd_q[CW-1:0] : '0;

	assign head_nx  = (head == PW'(DEPTH - 1)) ? '0 : head + 1'b1;
	assign count_nx = (count == CW'(DEPTH)) ? count : count + 1'b1;

	assign start_sum = {1'b0, head} + (PW+1)'(DEPTH) - (PW+1)'(count);
	assign start     = (start_sum >= (PW+1)'(DEPTH)) ? PW'(start_sum - (PW+1)'(DEPTH))
	                                                 : PW'(start_sum);

	assign span_w  = {1'b0, hi_q} - {1'b0, lo_q} + 1'b1;
	assign mid_nx  = lo_q + PW'(span_w >> 1);
	assign rd_base = cmd.rd_first ? start : start_q;
	assign rd_off  = cmd.rd_first ? '0 : mid_nx;
	assign psum    = {1'b0, rd_base} + {1'b0, rd_off};
	assign phys    = (psum >= (PW+1)'(DEPTH)) ? PW'(psum - (PW+1)'(DEPTH)) : PW'(psum);
	assign rd_addr = base_q + AW'(phys);
	assign wr_addr = base_q + AW'(head);

	always_ff @(posedge clk) begin
		if (cmd.append) ring_mem[wr_addr] <= {payload_q, stamp_q};
		if (cmd.rd_first || cmd.rd_mid) ring_rd_q <= ring_mem[rd_addr];
	end

	assign rd_stamp = ring_rd_q[STAMP_W-1:0];
	assign early    = (rd_stamp > stamp_q);

	always_ff @(posedge clk) begin
		if (cmd.rd_first) begin
			start_q <= start;
			lo_q    <= '0;
			hi_q    <= PW'(count - 1'b1);
		end
		if (cmd.rd_mid) mid_q <= mid_nx;
		if (cmd.cmp_mid) begin
			if (!early) begin
				lo_q       <= mid_q;
				res_data_q <= ring_rd_q;
			end else begin
				hi_q <= mid_q - 1'b1;
			end
		end
		if (cmd.chk_first) begin
			res_found_q <= 1'b1;
			res_bf_q    <= early;
			res_data_q  <= ring_rd_q;
		end
		if (cmd.set_empty) begin
			res_found_q <= 1'b0;
			res_bf_q    <= 1'b0;
			res_data_q  <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			earliest_q <= '0;
			latest_q   <= '0;
			seen_q     <= 1'b0;
		end else if (cmd.append) begin
			seen_q <= 1'b1;
			if (!seen_q) begin
				earliest_q <= stamp_q;
				latest_q   <= stamp_q;
			end else begin
				if (stamp_q > latest_q) latest_q <= stamp_q;
				if (stamp_q < earliest_q) earliest_q <= stamp_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			m_tdata_q <= {latest_q, earliest_q, res_data_q};
			m_tuser_q <= {res_bf_q, res_found_q};
		end
	end

	assign sts.query    = query_q;
	assign sts.veh_ok   = veh_ok_q;
	assign sts.hit      = veh_ok_q && (count != '0);
	assign sts.early    = early;
	assign sts.more     = (lo_q < hi_q);
	assign sts.out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
